/* design/tlut_pkg.sv */
// shared constants, types and arithmetic helpers of the trilinear lookup table
package tlut_pkg;

  localparam int GRID_POINTS = 7;
  localparam int CHANNELS    = 32;
  localparam int VALUE_BITS  = 16;
  localparam int FRAC_BITS   = 12;

  // widths fixed by the item fields
  localparam int COORD_W = 15;
  localparam int IDX_W   = 3;
  localparam int CH_W    = 5;

  localparam int NODES       = GRID_POINTS * GRID_POINTS * GRID_POINTS;
  localparam int DEPTH       = NODES * CHANNELS;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int NODE_W      = $clog2(NODES);
  localparam int COORD_LIMIT = ((GRID_POINTS - 1) << FRAC_BITS) - 1;
  localparam int WIDE_W      = VALUE_BITS + 2;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic        [FRAC_BITS-1:0]  frac_t;

  // tag of one table read pair travelling along the blend stages
  typedef struct packed {
    logic            valid;
    logic [1:0]      pair;
    logic [CH_W-1:0] channel;
  } rd_tag_t;

  // one finished channel result
  typedef struct packed {
    logic            valid;
    logic [CH_W-1:0] channel;
    value_t          value;
    logic            last;
  } result_t;

  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] c);
    if (c > COORD_W'(COORD_LIMIT)) return COORD_W'(COORD_LIMIT);
    return c;
  endfunction

  function automatic value_t sat_value(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'((1 << (VALUE_BITS - 1)) - 1);
    lo = -hi - WIDE_W'(1);
    if (v > hi) return hi[VALUE_BITS-1:0];
    if (v < lo) return lo[VALUE_BITS-1:0];
    return v[VALUE_BITS-1:0];
  endfunction

  // a + floor(((b - a) * f + half) / 2^FRAC_BITS), rounds half up
  function automatic logic signed [WIDE_W-1:0] lerp(input value_t a, input value_t b,
                                                     input frac_t f);
    logic signed [VALUE_BITS:0]             diff;
    logic signed [VALUE_BITS+FRAC_BITS+1:0] prod;
    logic signed [WIDE_W-1:0]               step;
    diff = $signed({b[VALUE_BITS-1], b}) - $signed({a[VALUE_BITS-1], a});
    prod = diff * $signed({1'b0, f});
    prod = prod + (VALUE_BITS + FRAC_BITS + 2)'(1 << (FRAC_BITS - 1));
    step = prod[VALUE_BITS+FRAC_BITS+1:FRAC_BITS];
    return $signed({{2{a[VALUE_BITS-1]}}, a}) + step;
  endfunction

endpackage

/* design/tlut_in_if.sv */
// input channel: write and query items
interface tlut_in_if import tlut_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic        [COORD_W-1:0]   coord_x;
  logic        [COORD_W-1:0]   coord_y;
  logic        [COORD_W-1:0]   coord_z;
  logic        [IDX_W-1:0]     node_x;
  logic        [IDX_W-1:0]     node_y;
  logic        [IDX_W-1:0]     node_z;
  logic        [CH_W-1:0]      write_channel;
  logic signed [15:0]          entry_value;

  modport source (output valid, command, coord_x, coord_y, coord_z, node_x, node_y, node_z,
                  write_channel, entry_value, input ready);
  modport sink   (input valid, command, coord_x, coord_y, coord_z, node_x, node_y, node_z,
                  write_channel, entry_value, output ready);
endinterface

/* design/tlut_out_if.sv */
// output channel: one interpolated channel result per transfer
interface tlut_out_if import tlut_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CH_W-1:0]     channel;
  logic signed [15:0]  value;
  logic                last;

  modport source (output valid, channel, value, last, input ready);
  modport sink   (input valid, channel, value, last, output ready);
endinterface

/* design/tlut_ram.sv */
// generic ram: one write port, two registered read ports
module tlut_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while re_i is low
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

/* design/tlut_interp.sv */
// blend stages: x pairs, then y pairs, then z
module tlut_interp import tlut_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    stall_i,
  input  rd_tag_t issue_i,
  input  value_t  rdata_a_i,
  input  value_t  rdata_b_i,
  input  frac_t   fx_i,
  input  frac_t   fy_i,
  input  frac_t   fz_i,
  output result_t result_o
);

  rd_tag_t s1_q, s2_q, s3_q;
  value_t  x_q, x_prev_q, y_q, y_prev_q;

  // tags follow the ram read data, frozen on a stall
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else if (!stall_i) begin
      s1_q <= issue_i;
      s2_q <= s1_q;
      s3_q <= '{valid:   s2_q.valid & s2_q.pair[0],
                pair:    s2_q.pair,
                channel: s2_q.channel};
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_i) begin
      if (s1_q.valid) begin
        x_q <= sat_value(lerp(rdata_a_i, rdata_b_i, fx_i));
      end
      if (s2_q.valid) begin
        x_prev_q <= x_q;
      end
      if (s2_q.valid && s2_q.pair[0]) begin
        y_q <= sat_value(lerp(x_prev_q, x_q, fy_i));
      end
      if (s3_q.valid) begin
        y_prev_q <= y_q;
      end
    end
  end

  always_comb begin
    result_o.valid   = s3_q.valid & s3_q.pair[1];
    result_o.channel = s3_q.channel;
    result_o.value   = sat_value(lerp(y_prev_q, y_q, fz_i));
    result_o.last    = (s3_q.channel == CH_W'(CHANNELS - 1));
  end

endmodule

/* design/multichannel_trilinear_lut.sv */
// top level of the multichannel trilinear lookup table
//
// The block keeps a 7x7x7 grid of nodes with 32 signed Q3.12 values each in one
// table memory of 10976 words that has a write port and two registered read
// ports. A write item (command 0) stores its value at the clock edge of the
// transfer; writes to a node or channel outside the grid are dropped. A query
// item (command 1) clamps each coordinate just below 6.0, then reads the table
// two words at a time (the x and x+1 neighbors of one y,z corner pair), so each
// channel takes four reads, and a query keeps the block busy until its last
// result has left the output, longer while the output is stalled. The read port
// count of the table memory sets the number of reads per channel. Results come
// out in channel order, the last one flagged. While a query runs the input is
// not ready, so no write can meet a pending read. The table has no reset;
// reading a node never written returns whatever the memory holds.
module multichannel_trilinear_lut import tlut_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  tlut_in_if.sink    in_i,
  tlut_out_if.source out_o
);

  logic            busy_q;
  logic            rd_active_q;
  logic [CH_W-1:0] rd_ch_q;
  logic [1:0]      rd_pair_q;
  frac_t           fx_q, fy_q, fz_q;
  logic [NODE_W-1:0] base_q;

  logic            out_valid_q;
  logic [CH_W-1:0] out_channel_q;
  value_t          out_value_q;
  logic            out_last_q;

  logic            in_xfer;
  logic            query_xfer;
  logic            write_ok;
  logic            stall;
  logic            ram_re;
  logic            last_xfer;
  logic [COORD_W-1:0] cx, cy, cz;
  logic [NODE_W-1:0] qbase;
  logic [NODE_W-1:0] wnode;
  logic [NODE_W-1:0] rnode;
  logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
  value_t          rdata_a, rdata_b;
  rd_tag_t         issue;
  result_t         result;

  // input handshake, no new item while a query is running
  assign in_i.ready = ~busy_q;
  assign in_xfer    = in_i.valid & in_i.ready;
  assign query_xfer = in_xfer & in_i.command;

  // the pipeline freezes when a result waits at the output
  assign stall     = out_valid_q & ~out_o.ready;
  assign last_xfer = out_valid_q & out_o.ready & out_last_q;

  // write address and range check of the entry
  assign write_ok = in_xfer & ~in_i.command
                  & (32'(in_i.node_x) < GRID_POINTS)
                  & (32'(in_i.node_y) < GRID_POINTS)
                  & (32'(in_i.node_z) < GRID_POINTS)
                  & (32'(in_i.write_channel) < CHANNELS);
  assign wnode = NODE_W'(in_i.node_x) * NODE_W'(GRID_POINTS * GRID_POINTS)
               + NODE_W'(in_i.node_y) * NODE_W'(GRID_POINTS)
               + NODE_W'(in_i.node_z);
  assign waddr = ADDR_W'(wnode) * ADDR_W'(CHANNELS) + ADDR_W'(in_i.write_channel);

  // clamp coordinates and form the lower corner node of the cell
  assign cx = clamp_coord(in_i.coord_x);
  assign cy = clamp_coord(in_i.coord_y);
  assign cz = clamp_coord(in_i.coord_z);
  assign qbase = NODE_W'(cx[COORD_W-1:FRAC_BITS]) * NODE_W'(GRID_POINTS * GRID_POINTS)
               + NODE_W'(cy[COORD_W-1:FRAC_BITS]) * NODE_W'(GRID_POINTS)
               + NODE_W'(cz[COORD_W-1:FRAC_BITS]);

  // read pair order: (y,z), (y+1,z), (y,z+1), (y+1,z+1); port b is x+1
  assign rnode   = base_q + (rd_pair_q[0] ? NODE_W'(GRID_POINTS) : '0)
                 + NODE_W'(rd_pair_q[1]);
  assign raddr_a = ADDR_W'(rnode) * ADDR_W'(CHANNELS) + ADDR_W'(rd_ch_q);
  assign raddr_b = raddr_a + ADDR_W'(GRID_POINTS * GRID_POINTS * CHANNELS);
  assign ram_re  = rd_active_q & ~stall;

  assign issue.valid   = ram_re;
  assign issue.pair    = rd_pair_q;
  assign issue.channel = rd_ch_q;

  // read sequencer and query control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rd_active_q <= 1'b0;
      rd_ch_q     <= '0;
      rd_pair_q   <= '0;
    end else begin
      if (query_xfer) begin
        busy_q      <= 1'b1;
        rd_active_q <= 1'b1;
        rd_ch_q     <= '0;
        rd_pair_q   <= '0;
      end else begin
        if (last_xfer) begin
          busy_q <= 1'b0;
        end
        if (ram_re) begin
          rd_pair_q <= rd_pair_q + 2'd1;
          if (rd_pair_q == 2'd3) begin
            rd_ch_q <= rd_ch_q + CH_W'(1);
            if (rd_ch_q == CH_W'(CHANNELS - 1)) begin
              rd_active_q <= 1'b0;
            end
          end
        end
      end
    end
  end

  // query operands, held for the whole query
  always_ff @(posedge clk_i) begin
    if (query_xfer) begin
      fx_q   <= cx[FRAC_BITS-1:0];
      fy_q   <= cy[FRAC_BITS-1:0];
      fz_q   <= cz[FRAC_BITS-1:0];
      base_q <= qbase;
    end
  end

  tlut_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (write_ok),
    .waddr_i   (waddr),
    .wdata_i   (in_i.entry_value),
    .re_i      (ram_re),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  tlut_interp u_interp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stall_i   (stall),
    .issue_i   (issue),
    .rdata_a_i (rdata_a),
    .rdata_b_i (rdata_b),
    .fx_i      (fx_q),
    .fy_i      (fy_q),
    .fz_i      (fz_q),
    .result_o  (result)
  );

  // output register, loads a new result unless the current one is stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!stall) begin
      out_valid_q <= result.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall && result.valid) begin
      out_channel_q <= result.channel;
      out_value_q   <= result.value;
      out_last_q    <= result.last;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.channel = out_channel_q;
  assign out_o.value   = out_value_q;
  assign out_o.last    = out_last_q;

  // a query transfer closes the input until its last result leaves
  a_query_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_xfer |=> !in_i.ready)
    else $error("input ready right after a query transfer");

  // results appear only inside a running query
  a_result_in_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> busy_q)
    else $error("result outside a query");

  // table reads are issued only for a running query
  a_read_in_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_active_q |-> busy_q)
    else $error("read sequencer active while idle");

endmodule
